// ===== hdl/dsq_pkg.sv =====
package dsq_pkg;

    localparam int CHANNELS  = 3;
    localparam int TIME_BITS = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_PIN_CHANGE = 2'd0;
    localparam logic [1:0] CMD_SAMPLE     = 2'd1;
    localparam logic [1:0] CMD_READ_EDGE  = 2'd2;
    localparam logic [1:0] CMD_LOAD_INIT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_NOTIFY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW      = 2'd3;

    localparam logic [15:0]         WINDOW_RESET      = 16'd5000;
    localparam logic [3:0]          NEEDED_RESET      = 4'd3;
    localparam logic [CHANNELS-1:0] EDGE_NOTIFY_RESET = CHANNELS'(1);
    localparam logic [CHANNELS-1:0] ACTIVE_LOW_RESET  = {CHANNELS{1'b1}};

    typedef struct packed {
        logic [15:0]         debounce_window;
        logic [3:0]          stable_samples_needed;
        logic [CHANNELS-1:0] edge_notify_mask;
        logic [CHANNELS-1:0] active_low_mask;
    } dsq_cfg_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [1:0]           channel;
        logic                 pin_level;
        logic [TIME_BITS-1:0] time_us;
    } dsq_item_t;

    typedef struct packed {
        logic       notify_valid;
        logic [1:0] notify_channel;
        logic       notify_level;
        logic       notify_is_edge;
        logic [2:0] stable_levels;
        logic       edge_flag_read;
    } dsq_result_t;

endpackage

// ===== hdl/debounce_stability_qualifier_core.sv =====
// a beat moves from the input register to the result register on its way to m_tdata
// throughput: one beat per cycle unless m_tready stalls; channel state is read, updated
// and written as the beat fires; a stalled result still lets an idle input register fill
// reset: aresetn synchronous active low; clears all channel state to zero and
// loads the configuration defaults (window 5000, 3 samples, notify mask 1, active low 7)
module debounce_stability_qualifier_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // channel, pin_level, time_us, zero pad
    input  logic [1:0]                    s_tuser,  // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // notify_valid, notify_channel,
                                                    // notify_level, stable_levels,
                                                    // edge_flag_read
    output logic [0:0]                    m_tuser,  // notify_is_edge
    input  logic                          cfg_we,
    input  logic [dsq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsq_pkg::CFG_W-1:0]     cfg_wdata
);
    import dsq_pkg::*;

    dsq_cfg_t    cfg;
    dsq_item_t   item_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    dsq_result_t result;
    dsq_result_t result_reg;
    logic        fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    dsq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dsq_channel_logic u_logic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.cmd       <= s_tuser;
            item_reg.channel   <= s_tdata[1:0];
            item_reg.pin_level <= s_tdata[2];
            item_reg.time_us   <= s_tdata[34:3];
        end
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.edge_flag_read, result_reg.stable_levels,
                       result_reg.notify_level, result_reg.notify_channel,
                       result_reg.notify_valid};
    assign m_tuser  = result_reg.notify_is_edge;

endmodule

// ===== hdl/dsq_cfg_regs.sv =====
module dsq_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dsq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsq_pkg::CFG_W-1:0]     cfg_wdata,
    output dsq_pkg::dsq_cfg_t             cfg
);
    import dsq_pkg::*;

    dsq_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_window       <= WINDOW_RESET;
            cfg_reg.stable_samples_needed <= NEEDED_RESET;
            cfg_reg.edge_notify_mask      <= EDGE_NOTIFY_RESET;
            cfg_reg.active_low_mask       <= ACTIVE_LOW_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE_WINDOW: cfg_reg.debounce_window <= cfg_wdata[15:0];
                REG_STABLE_NEEDED:   cfg_reg.stable_samples_needed <= cfg_wdata[3:0];
                REG_EDGE_NOTIFY:     cfg_reg.edge_notify_mask <= cfg_wdata[CHANNELS-1:0];
                REG_ACTIVE_LOW:      cfg_reg.active_low_mask <= cfg_wdata[CHANNELS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/dsq_channel_logic.sv =====
module dsq_channel_logic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  dsq_pkg::dsq_item_t   item,
    input  dsq_pkg::dsq_cfg_t    cfg,
    output dsq_pkg::dsq_result_t result
);
    import dsq_pkg::*;

    logic [CHANNELS-1:0]  deb_reg, deb_next;
    logic [CHANNELS-1:0]  stable_reg, stable_next;
    logic [CHANNELS-1:0]  edge_reg, edge_next;
    logic [CHANNELS-1:0]  raw_reg, raw_next;
    logic [TIME_BITS-1:0] time_reg [CHANNELS];
    logic [TIME_BITS-1:0] time_next [CHANNELS];
    logic [3:0]           cnt_reg [CHANNELS];
    logic [3:0]           cnt_next [CHANNELS];

    always_comb begin
        logic                 lvl;
        logic [TIME_BITS-1:0] diff;
        logic [3:0]           cnt_inc;
        deb_next    = deb_reg;
        stable_next = stable_reg;
        edge_next   = edge_reg;
        raw_next    = raw_reg;
        time_next   = time_reg;
        cnt_next    = cnt_reg;
        result      = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            lvl     = item.pin_level ^ cfg.active_low_mask[k];
            diff    = item.time_us - time_reg[k];
            cnt_inc = cnt_reg[k] + 4'd1;
            if (item.channel == 2'(k)) begin
                case (item.cmd)
                    CMD_PIN_CHANGE: begin
                        if (lvl != raw_reg[k]) begin
                            raw_next[k] = lvl;
                            if (diff > TIME_BITS'(cfg.debounce_window)) begin
                                deb_next[k]  = lvl;
                                time_next[k] = item.time_us;
                                cnt_next[k]  = 4'd0;
                                if (lvl && !deb_reg[k]) begin
                                    edge_next[k] = 1'b1;
                                    if (cfg.edge_notify_mask[k]) begin
                                        result.notify_valid   = 1'b1;
                                        result.notify_channel = item.channel;
                                        result.notify_level   = 1'b1;
                                        result.notify_is_edge = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    CMD_SAMPLE: begin
                        if (lvl == deb_reg[k]) begin
                            if (cnt_reg[k] < cfg.stable_samples_needed) begin
                                cnt_next[k] = cnt_inc;
                                if (cnt_inc >= cfg.stable_samples_needed &&
                                    stable_reg[k] != deb_reg[k]) begin
                                    stable_next[k]        = deb_reg[k];
                                    result.notify_valid   = 1'b1;
                                    result.notify_channel = item.channel;
                                    result.notify_level   = deb_reg[k];
                                end
                            end
                        end else begin
                            deb_next[k] = lvl;
                            cnt_next[k] = 4'd0;
                        end
                    end
                    CMD_READ_EDGE: begin
                        result.edge_flag_read = edge_reg[k];
                        edge_next[k]          = 1'b0;
                    end
                    CMD_LOAD_INIT: begin
                        deb_next[k]    = lvl;
                        stable_next[k] = lvl;
                        raw_next[k]    = lvl;
                        cnt_next[k]    = cfg.stable_samples_needed;
                    end
                    default: begin
                    end
                endcase
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (k < CHANNELS) begin
                result.stable_levels[k] = stable_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg    <= '0;
            stable_reg <= '0;
            edge_reg   <= '0;
            raw_reg    <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                time_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
        end else if (fire) begin
            deb_reg    <= deb_next;
            stable_reg <= stable_next;
            edge_reg   <= edge_next;
            raw_reg    <= raw_next;
            time_reg   <= time_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== verif/tb_debounce_stability_qualifier_core.sv =====
module tb_debounce_stability_qualifier_core;
    import dsq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;  // channel, pin_level, time_us, zero pad
    logic [1:0]           s_tuser   = '0;  // cmd
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;         // notify_valid, notify_channel, notify_level,
                                           // stable_levels, edge_flag_read
    logic [0:0]           m_tuser;         // notify_is_edge
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    debounce_stability_qualifier_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predicted channel state and configuration
    logic [15:0]         win_us;
    logic [3:0]          need_cnt;
    logic [CHANNELS-1:0] notify_mask;
    logic [CHANNELS-1:0] invert_mask;
    logic [CHANNELS-1:0] deb_lvl;
    logic [CHANNELS-1:0] stab_lvl;
    logic [CHANNELS-1:0] edge_seen;
    logic [CHANNELS-1:0] raw_seen;
    logic [31:0]         change_stamp [CHANNELS];
    logic [3:0]          agree_cnt [CHANNELS];

    dsq_item_t   queued_items [$];
    dsq_result_t expected_results [$];

    int unsigned cycle_count;
    int          error_count;
    int          offered_beats;
    int          beats_in;
    int          beats_out;
    int          notify_seen;
    int          edge_reads_set;
    int          stray_channel_beats;
    int          config_count;
    int          hold_requests;
    int          hold_starts;
    int          hold_left;
    int          tx_gap;
    int          rx_gap;
    int          rx_seen;
    bit          tx_idle_on;
    bit          rx_idle_on;
    logic [31:0] now_us;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_channels();
        win_us      = WINDOW_RESET;
        need_cnt    = NEEDED_RESET;
        notify_mask = EDGE_NOTIFY_RESET;
        invert_mask = ACTIVE_LOW_RESET;
        deb_lvl     = '0;
        stab_lvl    = '0;
        edge_seen   = '0;
        raw_seen    = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            change_stamp[k] = '0;
            agree_cnt[k]    = '0;
        end
    endfunction

    function automatic dsq_result_t qualify_item(dsq_item_t it);
        dsq_result_t r;
        int          ch;
        logic        lvl;
        logic        prev;
        logic [31:0] since_us;
        r  = '0;
        ch = it.channel;
        if (ch < CHANNELS) begin
            lvl = it.pin_level ^ invert_mask[ch];
            case (it.cmd)
                CMD_PIN_CHANGE: begin
                    if (lvl != raw_seen[ch]) begin
                        raw_seen[ch] = lvl;
                        since_us = it.time_us - change_stamp[ch];
                        if (since_us > {16'd0, win_us}) begin
                            prev            = deb_lvl[ch];
                            deb_lvl[ch]     = lvl;
                            change_stamp[ch] = it.time_us;
                            agree_cnt[ch]   = '0;
                            if (lvl && !prev) begin
                                edge_seen[ch] = 1'b1;
                                if (notify_mask[ch]) begin
                                    r.notify_valid   = 1'b1;
                                    r.notify_channel = it.channel;
                                    r.notify_level   = 1'b1;
                                    r.notify_is_edge = 1'b1;
                                end
                            end
                        end
                    end
                end
                CMD_SAMPLE: begin
                    if (lvl == deb_lvl[ch]) begin
                        if (agree_cnt[ch] < need_cnt) begin
                            agree_cnt[ch] = agree_cnt[ch] + 4'd1;
                            if (agree_cnt[ch] >= need_cnt && stab_lvl[ch] != deb_lvl[ch]) begin
                                stab_lvl[ch]     = deb_lvl[ch];
                                r.notify_valid   = 1'b1;
                                r.notify_channel = it.channel;
                                r.notify_level   = stab_lvl[ch];
                            end
                        end
                    end else begin
                        deb_lvl[ch]   = lvl;
                        agree_cnt[ch] = '0;
                    end
                end
                CMD_READ_EDGE: begin
                    r.edge_flag_read = edge_seen[ch];
                    edge_seen[ch]    = 1'b0;
                end
                CMD_LOAD_INIT: begin
                    deb_lvl[ch]   = lvl;
                    stab_lvl[ch]  = lvl;
                    raw_seen[ch]  = lvl;
                    agree_cnt[ch] = need_cnt;
                end
                default: begin
                end
            endcase
        end
        r.stable_levels = stab_lvl;
        return r;
    endfunction

    function automatic dsq_item_t make_item(logic [1:0] cmd, logic [1:0] ch, logic pin,
                                            logic [31:0] t);
        dsq_item_t it;
        it.cmd       = cmd;
        it.channel   = ch;
        it.pin_level = pin;
        it.time_us   = t;
        return it;
    endfunction

    task automatic flag_mismatch(string field, int got, int want);
        $display("mismatch on result %0d, %s: got %0d, want %0d", beats_out, field, got, want);
        error_count++;
    endtask

    // sender
    always @(negedge aclk) begin
        dsq_item_t it;
        if (aresetn) begin
            if (!(s_tvalid && beats_in != offered_beats)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (queued_items.size() != 0) begin
                    it = queued_items.pop_front();
                    s_tdata  <= {5'd0, it.time_us, it.pin_level, it.channel};
                    s_tuser  <= it.cmd;
                    s_tvalid <= 1'b1;
                    offered_beats++;
                    tx_gap = tx_idle_on ? $urandom_range(0, 4) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // input beats feed the predictor
    always @(posedge aclk) begin
        dsq_item_t it;
        if (aresetn && s_tvalid && s_tready) begin
            it = make_item(s_tuser, s_tdata[1:0], s_tdata[2], s_tdata[34:3]);
            if (it.channel >= CHANNELS) stray_channel_beats++;
            expected_results.push_back(qualify_item(it));
            beats_in++;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (beats_out != rx_seen) begin
                rx_seen = beats_out;
                rx_gap  = rx_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (hold_starts < hold_requests) begin
                hold_starts++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        dsq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (m_tdata[0]) notify_seen++;
            if (m_tdata[7]) edge_reads_set++;
            if (expected_results.size() == 0) begin
                flag_mismatch("beat with nothing expected", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.notify_valid)
                    flag_mismatch("notify_valid", m_tdata[0], want.notify_valid);
                if (m_tdata[2:1] !== want.notify_channel)
                    flag_mismatch("notify_channel", m_tdata[2:1], want.notify_channel);
                if (m_tdata[3] !== want.notify_level)
                    flag_mismatch("notify_level", m_tdata[3], want.notify_level);
                if (m_tuser[0] !== want.notify_is_edge)
                    flag_mismatch("notify_is_edge", m_tuser[0], want.notify_is_edge);
                if (m_tdata[6:4] !== want.stable_levels)
                    flag_mismatch("stable_levels", m_tdata[6:4], want.stable_levels);
                if (m_tdata[7] !== want.edge_flag_read)
                    flag_mismatch("edge_flag_read", m_tdata[7], want.edge_flag_read);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain_all();
        while (queued_items.size() != 0 || beats_in != offered_beats ||
               expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE_WINDOW: win_us      = val;
            REG_STABLE_NEEDED:   need_cnt    = val[3:0];
            REG_EDGE_NOTIFY:     notify_mask = val[CHANNELS-1:0];
            REG_ACTIVE_LOW:      invert_mask = val[CHANNELS-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_config(logic [15:0] win, logic [3:0] need, logic [2:0] notify,
                              logic [2:0] invert);
        drain_all();
        write_reg(REG_DEBOUNCE_WINDOW, win);
        write_reg(REG_STABLE_NEEDED, {12'd0, need});
        write_reg(REG_EDGE_NOTIFY, {13'd0, notify});
        write_reg(REG_ACTIVE_LOW, {13'd0, invert});
        config_count++;
    endtask

    function automatic logic [31:0] next_step();
        case ($urandom_range(0, 5))
            0:       return {16'd0, win_us};
            1:       return {16'd0, win_us} + 32'd1;
            2:       return $urandom_range(0, win_us);
            3:       return {16'd0, win_us} + $urandom_range(1, 20000);
            4:       return $urandom;
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    // bounce, settle, a run of samples, and sometimes an edge read or a level load
    function automatic int push_press(logic [1:0] ch);
        logic pin;
        int   n;
        int   cnt;
        pin = 1'($urandom_range(0, 1));
        cnt = 0;
        n   = $urandom_range(0, need_cnt + 2);
        n   = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            now_us += $urandom_range(1, 60);
            queued_items.push_back(make_item(CMD_PIN_CHANGE, ch, (k % 2) ? pin : ~pin,
                                             now_us));
            cnt++;
        end
        now_us += next_step();
        queued_items.push_back(make_item(CMD_PIN_CHANGE, ch, pin, now_us));
        cnt++;
        n = $urandom_range(0, need_cnt + 2);
        for (int k = 0; k < n; k++) begin
            queued_items.push_back(make_item(CMD_SAMPLE, ch, pin, $urandom));
            cnt++;
        end
        if ($urandom_range(0, 2) == 0) begin
            queued_items.push_back(make_item(CMD_READ_EDGE, ch, 1'($urandom_range(0, 1)),
                                             $urandom));
            cnt++;
        end
        if ($urandom_range(0, 9) == 0) begin
            queued_items.push_back(make_item(CMD_LOAD_INIT, ch, 1'($urandom_range(0, 1)),
                                             $urandom));
            cnt++;
        end
        return cnt;
    endfunction

    function automatic void push_random_items(int count);
        int pushed;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(0, 3) != 0) begin
                pushed += push_press(2'($urandom_range(0, CHANNELS - 1)));
            end else begin
                queued_items.push_back(make_item(2'($urandom_range(0, 3)),
                                                 2'($urandom_range(0, 3)),
                                                 1'($urandom_range(0, 1)), $urandom));
                pushed++;
            end
        end
    endfunction

    initial begin
        clear_channels();
        now_us     = 32'd0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration: window 5000, 3 samples, notify ch0, all inverted
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd0, 1'b0, 32'd100));
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd0, 1'b0, 32'd200));
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd0, 1'b1, 32'd5000));
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd0, 1'b0, 32'd5001));
        repeat (3) queued_items.push_back(make_item(CMD_SAMPLE, 2'd0, 1'b0, 32'd0));
        queued_items.push_back(make_item(CMD_READ_EDGE, 2'd0, 1'b0, 32'd0));
        queued_items.push_back(make_item(CMD_READ_EDGE, 2'd0, 1'b1, 32'd0));
        queued_items.push_back(make_item(CMD_SAMPLE, 2'd0, 1'b1, 32'd0));
        queued_items.push_back(make_item(CMD_LOAD_INIT, 2'd1, 1'b0, 32'hFFFF_FFFF));
        queued_items.push_back(make_item(CMD_READ_EDGE, 2'd3, 1'b1, 32'd0));
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd3, 1'b1, 32'hFFFF_FFFF));
        queued_items.push_back(make_item(CMD_SAMPLE, 2'd3, 1'b0, 32'hFFFF_FFFF));
        queued_items.push_back(make_item(CMD_LOAD_INIT, 2'd3, 1'b0, 32'd0));
        // wrapping time on ch2, no immediate notice since its mask bit is clear
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd2, 1'b0, 32'hFFFF_FFFF));
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd2, 1'b1, 32'h0000_1000));
        queued_items.push_back(make_item(CMD_PIN_CHANGE, 2'd2, 1'b0, 32'h0000_2000));
        queued_items.push_back(make_item(CMD_READ_EDGE, 2'd2, 1'b0, 32'd0));
        queued_items.push_back(make_item(CMD_SAMPLE, 2'd1, 1'b0, 32'd0));
        queued_items.push_back(make_item(CMD_SAMPLE, 2'd2, 1'b1, 32'd0));
        drain_all();

        now_us = 32'd10000;
        push_random_items(150);

        // long receiver hold-off while the sender keeps offering
        set_config(16'd0, 4'd1, 3'd7, 3'd0);
        hold_requests++;
        push_random_items(150);

        // sender pause halfway through
        set_config(16'hFFFF, 4'd15, 3'd0, 3'd5);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        push_random_items(80);
        drain_all();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        push_random_items(80);

        set_config(16'($urandom_range(0, 65535)), 4'd0, 3'd2, 3'd2);
        push_random_items(100);

        set_config(16'd300, 4'd4, 3'd7, 3'd7);
        now_us = 32'hFFFF_0000;
        hold_requests++;
        push_random_items(250);

        drain_all();
        repeat (8) @(posedge aclk);
        $display("%0d input beats over %0d register settings, %0d results checked",
                 beats_in, config_count + 1, beats_out);
        $display("%0d notifications, %0d edge flags read set, %0d beats on an absent channel",
                 notify_seen, edge_reads_set, stray_channel_beats);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
